// ----- sv/left_neighbour_value_finder_macros.svh -----
// assertion helpers used by the block's back module
`ifndef LEFT_NEIGHBOUR_VALUE_FINDER_MACROS_SVH
`define LEFT_NEIGHBOUR_VALUE_FINDER_MACROS_SVH

// property checked on every edge outside reset
`define LNVF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition on one edge implies a consequence on the next edge
`define LNVF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/lnvf_pkg.sv -----
package lnvf_pkg;

  localparam int VAL_W  = 6;
  localparam int LINK_W = 7;

  localparam logic [LINK_W-1:0] NO_PREV = 7'h7F;

  // one load handed from the front to the back
  typedef struct packed {
    logic              err;
    logic [LINK_W-1:0] n;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ERR,
    BK_LINK,
    BK_EMIT
  } back_state_t;

endpackage

// ----- sv/left_neighbour_value_finder.sv -----
// left neighbour value finder
// input channel: one permutation value per transaction (in_value, in_last),
// in position order; in_last on the final value starts the compute pass.
// the loader takes one value per cycle while no pass is running; in_stall
// stays high from the cycle after the last value until the final result
// of that pass has entered the output register.
// output channel: one transaction per position, from n-1 down to 0, with the
// largest smaller and smallest greater value found at earlier positions
// (-1 and n when there is none); out_done_res marks position 0. a load that
// is not a permutation of 0..n-1, or that overflows, gives one transaction
// with out_error and out_done_res set instead.
// each result takes a LINK step, which reads the link memories for its value,
// and an EMIT step, which reports it and unlinks the value; an error load
// passes from the job queue through the ERR step to the output register.
// out_stall holds the current result and pauses the pass in place.
// reset (rst_n low, synchronous) empties the load, the job queue and the
// output register; no clearing pass is needed.
module left_neighbour_value_finder #(
  parameter int MAX_LEN = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lnvf_pkg::VAL_W-1:0]  in_value,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lnvf_pkg::VAL_W-1:0]  out_position,
  output logic signed [lnvf_pkg::LINK_W-1:0] out_max_smaller,
  output logic [lnvf_pkg::LINK_W-1:0] out_min_greater,
  output logic                        out_error,
  output logic                        out_done_res
);

  import lnvf_pkg::*;

  localparam int AW = $clog2(MAX_LEN);

  logic             front_hold;
  logic             push, pop, q_empty, q_full, back_busy;
  job_t             push_job, pop_job;
  logic             perm_we, perm_re;
  logic [AW-1:0]    perm_waddr, perm_raddr;
  logic [VAL_W-1:0] perm_wdata, perm_rdata;

  // the permutation memory is owned by one side at a time
  assign front_hold = !q_empty || q_full || back_busy;

  lnvf_front #(.MAX_LEN(MAX_LEN)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_value   (in_value),
    .in_last    (in_last),
    .hold       (front_hold),
    .push       (push),
    .job        (push_job),
    .perm_we    (perm_we),
    .perm_waddr (perm_waddr),
    .perm_wdata (perm_wdata)
  );

  lnvf_ram #(.W(VAL_W), .DEPTH(MAX_LEN)) u_perm_ram (
    .clk   (clk),
    .we    (perm_we),
    .waddr (perm_waddr),
    .wdata (perm_wdata),
    .re    (perm_re),
    .raddr (perm_raddr),
    .rdata (perm_rdata)
  );

  lnvf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_job),
    .pop       (pop),
    .pop_data  (pop_job),
    .empty     (q_empty),
    .full      (q_full)
  );

  lnvf_back #(.MAX_LEN(MAX_LEN)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_data          (pop_job),
    .pop             (pop),
    .busy            (back_busy),
    .perm_re         (perm_re),
    .perm_raddr      (perm_raddr),
    .perm_rdata      (perm_rdata),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_position    (out_position),
    .out_max_smaller (out_max_smaller),
    .out_min_greater (out_min_greater),
    .out_error       (out_error),
    .out_done_res    (out_done_res)
  );

endmodule

// ----- sv/lnvf_ram.sv -----
module lnvf_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/lnvf_front.sv -----
module lnvf_front #(
  parameter int MAX_LEN = 64,
  localparam int AW     = $clog2(MAX_LEN),
  localparam int CNT_W  = $clog2(MAX_LEN + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [lnvf_pkg::VAL_W-1:0] in_value,
  input  logic                      in_last,
  input  logic                      hold,
  output logic                      push,
  output lnvf_pkg::job_t            job,
  output logic                      perm_we,
  output logic [AW-1:0]             perm_waddr,
  output logic [lnvf_pkg::VAL_W-1:0] perm_wdata
);

  import lnvf_pkg::*;

  logic [CNT_W-1:0]   cnt_r, cnt_nxt, ld_cnt;
  logic               err_r, err_nxt, ld_err;
  logic [VAL_W-1:0]   max_r, max_nxt, ld_max;
  logic [MAX_LEN-1:0] seen_r, seen_nxt, ld_seen;
  logic               accept;
  logic               bad;
  logic [AW-1:0]      idx;

  always_comb begin
    accept   = in_valid && !hold;
    in_stall = hold;
    bad      = ({1'b0, in_value} >= LINK_W'(MAX_LEN)) || (cnt_r == CNT_W'(MAX_LEN));
    idx      = in_value[AW-1:0];

    ld_cnt  = cnt_r;
    ld_err  = err_r;
    ld_max  = max_r;
    ld_seen = seen_r;
    if (accept) begin
      if (bad) begin
        ld_err = 1'b1;
      end else begin
        if (seen_r[idx]) begin
          ld_err = 1'b1;
        end
        ld_seen[idx] = 1'b1;
        ld_cnt       = CNT_W'(cnt_r + 1'b1);
        if (in_value > max_r) begin
          ld_max = in_value;
        end
      end
    end

    perm_we    = accept && !bad;
    perm_waddr = cnt_r[AW-1:0];
    perm_wdata = in_value;

    // a distinct load is a permutation exactly when its largest value is below n
    push    = accept && in_last;
    job.n   = LINK_W'(ld_cnt);
    job.err = ld_err || (ld_cnt == '0) || ({1'b0, ld_max} >= LINK_W'(ld_cnt));

    if (push) begin
      cnt_nxt  = '0;
      err_nxt  = 1'b0;
      max_nxt  = '0;
      seen_nxt = '0;
    end else begin
      cnt_nxt  = ld_cnt;
      err_nxt  = ld_err;
      max_nxt  = ld_max;
      seen_nxt = ld_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      err_r  <= 1'b0;
      max_r  <= '0;
      seen_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      err_r  <= err_nxt;
      max_r  <= max_nxt;
      seen_r <= seen_nxt;
    end
  end

endmodule

// ----- sv/lnvf_queue.sv -----
module lnvf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lnvf_pkg::job_t push_data,
  input  logic           pop,
  output lnvf_pkg::job_t pop_data,
  output logic           empty,
  output logic           full
);

  import lnvf_pkg::*;

  job_t       data_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  always_comb begin
    empty      = (cnt_r == 2'd0);
    full       = (cnt_r == 2'd2);
    do_push    = push && !full;
    do_pop     = pop && !empty;
    pop_data   = data_r[rd_ptr_r];
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      data_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- sv/lnvf_back.sv -----
`include "left_neighbour_value_finder_macros.svh"

module lnvf_back #(
  parameter int MAX_LEN = 64,
  localparam int AW     = $clog2(MAX_LEN)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  lnvf_pkg::job_t              q_data,
  output logic                        pop,
  output logic                        busy,
  output logic                        perm_re,
  output logic [AW-1:0]               perm_raddr,
  input  logic [lnvf_pkg::VAL_W-1:0]  perm_rdata,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lnvf_pkg::VAL_W-1:0]  out_position,
  output logic signed [lnvf_pkg::LINK_W-1:0] out_max_smaller,
  output logic [lnvf_pkg::LINK_W-1:0] out_min_greater,
  output logic                        out_error,
  output logic                        out_done_res
);

  import lnvf_pkg::*;

  back_state_t        state_r, state_nxt;
  logic [LINK_W-1:0]  n_r, n_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  logic [AW-1:0]      val_r, val_nxt;
  logic               pv_vld_r, pv_vld_nxt;
  logic               nx_vld_r, nx_vld_nxt;
  logic [MAX_LEN-1:0] prev_vld_r, prev_vld_nxt;
  logic [MAX_LEN-1:0] next_vld_r, next_vld_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]         out_position_r, out_position_nxt;
  logic signed [LINK_W-1:0] out_max_smaller_r, out_max_smaller_nxt;
  logic [LINK_W-1:0]        out_min_greater_r, out_min_greater_nxt;
  logic                     out_error_r, out_error_nxt;
  logic                     out_done_r, out_done_nxt;

  logic              out_free;
  logic [AW-1:0]     val;
  logic [LINK_W-1:0] nm1;
  logic [LINK_W-1:0] pv, nx;
  logic              link_re;
  logic              prev_we, next_we;
  logic [AW-1:0]     prev_waddr, next_waddr;
  logic [LINK_W-1:0] prev_wdata, next_wdata;
  logic [LINK_W-1:0] prev_rdata, next_rdata;

  lnvf_ram #(.W(LINK_W), .DEPTH(MAX_LEN)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .re    (link_re),
    .raddr (val),
    .rdata (prev_rdata)
  );

  lnvf_ram #(.W(LINK_W), .DEPTH(MAX_LEN)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .re    (link_re),
    .raddr (val),
    .rdata (next_rdata)
  );

  always_comb begin
    out_free = !out_valid_r || !out_stall;
    val      = perm_rdata[AW-1:0];
    nm1      = q_data.n - 7'd1;

    // links never written in this pass still hold their initial neighbors
    if (pv_vld_r) begin
      pv = prev_rdata;
    end else if (val_r == '0) begin
      pv = NO_PREV;
    end else begin
      pv = LINK_W'(val_r) - 7'd1;
    end
    nx = nx_vld_r ? next_rdata : LINK_W'(val_r) + 7'd1;

    state_nxt    = state_r;
    n_nxt        = n_r;
    pos_nxt      = pos_r;
    val_nxt      = val_r;
    pv_vld_nxt   = pv_vld_r;
    nx_vld_nxt   = nx_vld_r;
    prev_vld_nxt = prev_vld_r;
    next_vld_nxt = next_vld_r;
    pop          = 1'b0;
    perm_re      = 1'b0;
    perm_raddr   = pos_r;
    link_re      = 1'b0;
    prev_we      = 1'b0;
    next_we      = 1'b0;
    prev_waddr   = nx[AW-1:0];
    prev_wdata   = pv;
    next_waddr   = pv[AW-1:0];
    next_wdata   = nx;

    out_valid_nxt       = out_valid_r && out_stall;
    out_position_nxt    = out_position_r;
    out_max_smaller_nxt = out_max_smaller_r;
    out_min_greater_nxt = out_min_greater_r;
    out_error_nxt       = out_error_r;
    out_done_nxt        = out_done_r;

    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          if (q_data.err) begin
            state_nxt = BK_ERR;
          end else begin
            n_nxt        = q_data.n;
            pos_nxt      = nm1[AW-1:0];
            perm_re      = 1'b1;
            perm_raddr   = nm1[AW-1:0];
            prev_vld_nxt = '0;
            next_vld_nxt = '0;
            state_nxt    = BK_LINK;
          end
        end
      end
      BK_ERR: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_position_nxt    = '0;
          out_max_smaller_nxt = '0;
          out_min_greater_nxt = '0;
          out_error_nxt       = 1'b1;
          out_done_nxt        = 1'b1;
          state_nxt           = BK_IDLE;
        end
      end
      BK_LINK: begin
        link_re    = 1'b1;
        val_nxt    = val;
        pv_vld_nxt = prev_vld_r[val];
        nx_vld_nxt = next_vld_r[val];
        state_nxt  = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_position_nxt    = VAL_W'(pos_r);
          out_max_smaller_nxt = pv;
          out_min_greater_nxt = nx;
          out_error_nxt       = 1'b0;
          out_done_nxt        = (pos_r == '0);
          // unlink the value just reported
          if (pv != NO_PREV) begin
            next_we                  = 1'b1;
            next_vld_nxt[pv[AW-1:0]] = 1'b1;
          end
          if (nx < n_r) begin
            prev_we                  = 1'b1;
            prev_vld_nxt[nx[AW-1:0]] = 1'b1;
          end
          if (pos_r == '0) begin
            state_nxt = BK_IDLE;
          end else begin
            pos_nxt    = pos_r - 1'b1;
            perm_re    = 1'b1;
            perm_raddr = pos_r - 1'b1;
            state_nxt  = BK_LINK;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase

    busy            = (state_r != BK_IDLE);
    out_valid       = out_valid_r;
    out_position    = out_position_r;
    out_max_smaller = out_max_smaller_r;
    out_min_greater = out_min_greater_r;
    out_error       = out_error_r;
    out_done_res    = out_done_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      prev_vld_r  <= '0;
      next_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_vld_r  <= prev_vld_nxt;
      next_vld_r  <= next_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r               <= n_nxt;
    pos_r             <= pos_nxt;
    val_r             <= val_nxt;
    pv_vld_r          <= pv_vld_nxt;
    nx_vld_r          <= nx_vld_nxt;
    out_position_r    <= out_position_nxt;
    out_max_smaller_r <= out_max_smaller_nxt;
    out_min_greater_r <= out_min_greater_nxt;
    out_error_r       <= out_error_nxt;
    out_done_r        <= out_done_nxt;
  end

  `LNVF_ASSERT(a_link_val_in_range, state_r == BK_LINK |-> {1'b0, perm_rdata} < n_r, "value read back is not below n")
  `LNVF_ASSERT(a_err_result_alone, out_valid_r && out_error_r |-> out_done_r && out_position_r == '0, "error result is not a lone final result")
  `LNVF_ASSERT_NEXT(a_emit_wait_holds, state_r == BK_EMIT && !out_free, state_r == BK_EMIT && $stable(pos_r), "step advanced while the output was blocked")

endmodule

// ----- tb/testbench.sv -----
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lnvf_pkg::*;

  localparam int MAX_LEN = 64;

  typedef struct packed {
    logic [VAL_W-1:0]  position;
    logic [LINK_W-1:0] max_smaller;
    logic [LINK_W-1:0] min_greater;
    logic              error;
    logic              done_res;
  } neighbour_t;

  // keeps its own copy of the load and predicts the neighbour pairs per pass
  class neighbour_tracker_t;
    logic [VAL_W-1:0] stored [MAX_LEN];
    bit               seen [MAX_LEN];
    int unsigned      loaded;
    bit               bad_load;
    neighbour_t       pending [$];
    int unsigned      mismatches;
    int unsigned      good_runs;
    int unsigned      bad_runs;
    int unsigned      results_checked;

    function new();
      mismatches = 0;
      good_runs = 0;
      bad_runs = 0;
      results_checked = 0;
      clear_load();
    endfunction

    function void clear_load();
      foreach (seen[i]) seen[i] = 0;
      loaded = 0;
      bad_load = 0;
    endfunction

    function void note_value(logic [VAL_W-1:0] v, logic last);
      logic [LINK_W-1:0] below [MAX_LEN];
      logic [LINK_W-1:0] above [MAX_LEN];
      logic [VAL_W-1:0]  val;
      neighbour_t        r;
      int unsigned       n;
      if (loaded >= MAX_LEN) begin
        bad_load = 1;
      end else begin
        if (seen[v]) bad_load = 1;
        seen[v] = 1;
        stored[loaded] = v;
        loaded++;
      end
      if (!last) return;
      n = loaded;
      for (int i = 0; i < n; i++)
        if (stored[i] >= n) bad_load = 1;
      if (bad_load || n == 0) begin
        r = '0;
        r.error = 1;
        r.done_res = 1;
        pending.insert(pending.size(), r);
        bad_runs++;
      end else begin
        for (int i = 0; i < n; i++) begin
          below[i] = (i == 0) ? NO_PREV : LINK_W'(i - 1);
          above[i] = LINK_W'(i + 1);
        end
        // walk positions downward, unlinking each value after reporting it
        for (int p = n - 1; p >= 0; p--) begin
          val = stored[p];
          r.position = VAL_W'(p);
          r.max_smaller = below[val];
          r.min_greater = above[val];
          r.error = 0;
          r.done_res = (p == 0);
          pending.insert(pending.size(), r);
          if (below[val] != NO_PREV) above[below[val]] = above[val];
          if (above[val] < n) below[above[val]] = below[val];
        end
        good_runs++;
      end
      clear_load();
    endfunction

    function void compare_field(string what, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(neighbour_t got);
      neighbour_t want;
      results_checked++;
      if (pending.size() == 0) begin
        $display("%0t: result for position %0d with nothing expected, expected none, actual %h",
                 $time, got.position, got);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      compare_field("position", want.position, got.position);
      compare_field("max_smaller", $signed(want.max_smaller), $signed(got.max_smaller));
      compare_field("min_greater", want.min_greater, got.min_greater);
      compare_field("error", want.error, got.error);
      compare_field("done_res", want.done_res, got.done_res);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [VAL_W-1:0]  in_value = '0;
  logic              in_last = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [VAL_W-1:0]  out_position;
  logic signed [LINK_W-1:0] out_max_smaller;
  logic [LINK_W-1:0] out_min_greater;
  logic              out_error;
  logic              out_done_res;

  neighbour_tracker_t tracker = new();
  logic [VAL_W-1:0]  load_buf [$];
  int unsigned       items_sent = 0;
  bit                quiet = 0;

  left_neighbour_value_finder #(.MAX_LEN(MAX_LEN)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_value(in_value),
    .in_last(in_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_position(out_position),
    .out_max_smaller(out_max_smaller),
    .out_min_greater(out_min_greater),
    .out_error(out_error),
    .out_done_res(out_done_res)
  );

  always #10 clk = ~clk;

  task automatic send_item(logic [VAL_W-1:0] v, logic l);
    while (!quiet && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    in_last <= l;
    do @(posedge clk); while (in_stall);
    tracker.note_value(v, l);
    items_sent++;
  endtask

  task automatic send_load();
    for (int i = 0; i < load_buf.size(); i++)
      send_item(load_buf[i], i == load_buf.size() - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
  endtask

  function automatic void make_perm(int n);
    logic [VAL_W-1:0] t;
    int j;
    load_buf.delete();
    for (int i = 0; i < n; i++) load_buf.insert(load_buf.size(), VAL_W'(i));
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(i, 0);
      t = load_buf[i];
      load_buf[i] = load_buf[j];
      load_buf[j] = t;
    end
  endfunction

  // result side: random stall, check every accepted transaction
  initial begin
    neighbour_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.position = out_position;
        got.max_smaller = out_max_smaller;
        got.min_greater = out_min_greater;
        got.error = out_error;
        got.done_res = out_done_res;
        tracker.check_result(got);
      end
      out_stall <= !quiet && ($urandom_range(99) < 35);
    end
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int unsigned base;
    int n;
    int pick;
    int j;
    int k;
    bit full_done;
    bit overflow_done;
    full_done = 0;
    overflow_done = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed loads
    load_buf = '{6'd0};                    send_load();  // single element
    load_buf = '{6'd1};                    send_load();  // value not below n
    load_buf = '{6'd63};                   send_load();
    load_buf = '{6'd0, 6'd1};              send_load();
    load_buf = '{6'd1, 6'd0};              send_load();
    load_buf = '{6'd2, 6'd0, 6'd1};        send_load();
    load_buf = '{6'd3, 6'd1, 6'd0, 6'd2};  send_load();
    load_buf = '{6'd0, 6'd0};              send_load();  // duplicate
    load_buf = '{6'd2, 6'd62, 6'd0};       send_load();
    wait_drained();

    base = items_sent;
    while (items_sent < base + 360) begin
      quiet = (items_sent >= base + 140) && (items_sent < base + 200);
      if (!full_done && items_sent >= base + 90) begin
        make_perm(MAX_LEN);
        send_load();
        full_done = 1;
      end else if (!overflow_done && items_sent >= base + 230) begin
        // too many elements: full permutation with its last value replaced by two to four random values
        make_perm(MAX_LEN);
        load_buf.delete(load_buf.size() - 1);
        repeat ($urandom_range(3, 1))
          load_buf.insert(load_buf.size(), VAL_W'($urandom_range(63, 0)));
        load_buf.insert(load_buf.size(), VAL_W'($urandom_range(63, 0)));
        send_load();
        wait_drained();
        overflow_done = 1;
      end else begin
        n = ($urandom_range(99) < 5) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        pick = $urandom_range(99);
        if (pick < 70) begin
          make_perm(n);
        end else if (pick < 80) begin
          make_perm((n < 2) ? 2 : n);
          j = $urandom_range(load_buf.size() - 1, 0);
          k = (j + $urandom_range(load_buf.size() - 1, 1)) % load_buf.size();
          load_buf[j] = load_buf[k];
        end else if (pick < 90) begin
          make_perm(n);
          load_buf[$urandom_range(n - 1, 0)] = VAL_W'($urandom_range(63, n));
        end else begin
          load_buf.delete();
          repeat ($urandom_range(8, 1))
            load_buf.insert(load_buf.size(), VAL_W'($urandom_range(63, 0)));
        end
        send_load();
        if ($urandom_range(99) < 4) wait_drained();
      end
    end
    quiet = 0;

    wait_drained();
    repeat (20) @(posedge clk);
    $display("covered %0d loaded values: %0d permutations walked, %0d loads rejected",
             items_sent, tracker.good_runs, tracker.bad_runs);
    $display("%0d result transactions checked, %0d mismatches",
             tracker.results_checked, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
